/* rtl/lbs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED blink sequencer package
// Item kinds, sequencer phases and the stored command and state records.
// ----------------------------------------------------------------------------
package lbs_pkg;

	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_BLINK = 2'd1,
		KIND_ON    = 2'd2,
		KIND_OFF   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		PH_EMPTY = 3'd0,
		PH_IDLE  = 3'd1,
		PH_ON    = 3'd2,
		PH_OFF   = 3'd3,
		PH_PAUSE = 3'd4
	} phase_t;

	localparam int unsigned MS_BITS  = 16;
	localparam int unsigned LIM_BITS = 8;

	typedef struct packed {
		kind_t                mode;
		logic [MS_BITS-1:0]   on_t;
		logic [MS_BITS-1:0]   off_t;
		logic [LIM_BITS-1:0]  limit;
		logic [MS_BITS-1:0]   pause;
		logic                 fin;
	} cmd_t;

	typedef struct packed {
		phase_t phase;
		cmd_t   act;
		logic   pend_valid;
		cmd_t   pend;
		logic   led;
	} seq_state_t;

	typedef struct packed {
		kind_t                kind;
		logic [MS_BITS-1:0]   on_ms;
		logic [MS_BITS-1:0]   off_ms;
		logic [LIM_BITS-1:0]  cycle_limit;
		logic [MS_BITS-1:0]   post_pause_ms;
		logic                 fulfill;
	} item_t;

endpackage
`default_nettype wire

/* rtl/lbs_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED blink sequencer channels
// Valid/ready command channel and result channel.
// ----------------------------------------------------------------------------
interface lbs_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] on_ms;
	logic [15:0] off_ms;
	logic [7:0]  cycle_limit;
	logic [15:0] post_pause_ms;
	logic        fulfill;

	modport source (output valid, kind, on_ms, off_ms, cycle_limit, post_pause_ms,
		fulfill, input ready);
	modport sink (input valid, kind, on_ms, off_ms, cycle_limit, post_pause_ms,
		fulfill, output ready);
endinterface

interface lbs_res_if;
	logic valid;
	logic ready;
	logic led_level;
	logic busy_res;

	modport source (output valid, led_level, busy_res, input ready);
	modport sink (input valid, led_level, busy_res, output ready);
endinterface
`default_nettype wire

/* rtl/lbs_step.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED blink sequencer step
// Next-state logic for one item: time advance, pending slot, takeover, action.
// ----------------------------------------------------------------------------
module lbs_step #(
	parameter int unsigned TIME_BITS  = 16,
	parameter int unsigned COUNT_BITS = 8
) (
	input  lbs_pkg::item_t      item,
	input  lbs_pkg::seq_state_t st_cur,
	input  logic [TIME_BITS-1:0]  cd_cur,
	input  logic [COUNT_BITS-1:0] cyc_cur,
	output lbs_pkg::seq_state_t st_nxt,
	output logic [TIME_BITS-1:0]  cd_nxt,
	output logic [COUNT_BITS-1:0] cyc_nxt
);

	localparam int unsigned LW = (TIME_BITS > lbs_pkg::MS_BITS) ? TIME_BITS
		: lbs_pkg::MS_BITS;
	localparam int unsigned CW = (COUNT_BITS > lbs_pkg::LIM_BITS) ? COUNT_BITS
		: lbs_pkg::LIM_BITS;
	localparam logic [LW-1:0] TMAX = LW'({TIME_BITS{1'b1}});

	function automatic logic [TIME_BITS-1:0] load_time(
		input logic [lbs_pkg::MS_BITS-1:0] t);
		logic [LW-1:0] t_ext;
		logic [LW-1:0] t_sat;
		t_ext = LW'(t);
		t_sat = (t_ext > TMAX) ? TMAX : t_ext;
		return t_sat[TIME_BITS-1:0];
	endfunction

	lbs_pkg::seq_state_t   st;
	logic [TIME_BITS-1:0]  cd;
	logic [COUNT_BITS-1:0] cyc;
	logic [COUNT_BITS-1:0] cyc_inc;

	always_comb begin
		st      = st_cur;
		cd      = cd_cur;
		cyc     = cyc_cur;
		cyc_inc = cyc_cur + COUNT_BITS'(1);

		if (item.kind == lbs_pkg::KIND_TICK) begin
			if (cd != '0) begin
				cd = cd - TIME_BITS'(1);
			end
		end else begin
			st.pend      = '0;
			st.pend.mode = item.kind;
			if (item.kind == lbs_pkg::KIND_BLINK) begin
				st.pend.on_t  = item.on_ms;
				st.pend.off_t = item.off_ms;
				st.pend.limit = item.cycle_limit;
				st.pend.pause = item.post_pause_ms;
				st.pend.fin   = item.fulfill;
			end
			st.pend_valid = 1'b1;
		end

		if (st.pend_valid && (st.phase == lbs_pkg::PH_EMPTY ||
				(!st.act.fin && st.pend != st.act))) begin
			st.act        = st.pend;
			st.phase      = lbs_pkg::PH_IDLE;
			st.pend_valid = 1'b0;
			cd            = '0;
		end

		if (st.phase != lbs_pkg::PH_EMPTY && cd == '0) begin
			case (st.act.mode)
				lbs_pkg::KIND_ON: begin
					st.led   = 1'b1;
					st.phase = lbs_pkg::PH_EMPTY;
				end
				lbs_pkg::KIND_OFF: begin
					st.led   = 1'b0;
					st.phase = lbs_pkg::PH_EMPTY;
				end
				lbs_pkg::KIND_BLINK: begin
					case (st.phase)
						lbs_pkg::PH_IDLE: begin
							cyc      = '0;
							st.led   = 1'b1;
							cd       = load_time(st.act.on_t);
							st.phase = lbs_pkg::PH_ON;
						end
						lbs_pkg::PH_ON: begin
							st.led   = 1'b0;
							cd       = load_time(st.act.off_t);
							st.phase = lbs_pkg::PH_OFF;
						end
						lbs_pkg::PH_OFF: begin
							cyc = cyc_inc;
							if (st.act.limit == '0 || CW'(cyc_inc) < CW'(st.act.limit)) begin
								st.led   = 1'b1;
								cd       = load_time(st.act.on_t);
								st.phase = lbs_pkg::PH_ON;
							end else begin
								cd       = load_time(st.act.pause);
								st.phase = lbs_pkg::PH_PAUSE;
							end
						end
						lbs_pkg::PH_PAUSE: begin
							st.phase = lbs_pkg::PH_EMPTY;
						end
						default: begin
						end
					endcase
				end
				default: begin
				end
			endcase
		end
	end

	assign st_nxt  = st;
	assign cd_nxt  = cd;
	assign cyc_nxt = cyc;

endmodule
`default_nettype wire

/* rtl/led_blink_sequencer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED blink sequencer
// Drives one LED from blink/on/off commands and millisecond ticks.
//
//   Channel  Dir  Payload                                               Per item
//   cmd      in   kind, on_ms, off_ms, cycle_limit, post_pause_ms, fulfill  one
//   res      out  led_level, busy_res                                   one
//
// One transaction per cycle sustained while res is not stalled; a result is
// presented after the input register, then the state and result register.
// The sequencer step is one pass of next-state logic on the input register.
// Reset clears the sequencer to an empty slot with the LED dark.
// A stalled result holds the input register; cmd.ready drops only then.
// ----------------------------------------------------------------------------
module led_blink_sequencer #(
	parameter int unsigned TIME_BITS  = 16,
	parameter int unsigned COUNT_BITS = 8
) (
	input  wire          clk,
	input  wire          arst_n,
	lbs_cmd_if.sink      cmd,
	lbs_res_if.source    res
);

	logic                  item_v_s1;
	lbs_pkg::item_t        item_s1;
	logic                  adv;

	lbs_pkg::seq_state_t   st_q;
	lbs_pkg::seq_state_t   st_nxt;
	logic [TIME_BITS-1:0]  cd_q;
	logic [TIME_BITS-1:0]  cd_nxt;
	logic [COUNT_BITS-1:0] cyc_q;
	logic [COUNT_BITS-1:0] cyc_nxt;

	logic                  res_v_q;
	logic                  led_q;
	logic                  busy_q;

	assign adv       = item_v_s1 && (!res_v_q || res.ready);
	assign cmd.ready = !item_v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_v_s1 <= 1'b0;
		end else if (cmd.ready) begin
			item_v_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			item_s1.kind          <= lbs_pkg::kind_t'(cmd.kind);
			item_s1.on_ms         <= cmd.on_ms;
			item_s1.off_ms        <= cmd.off_ms;
			item_s1.cycle_limit   <= cmd.cycle_limit;
			item_s1.post_pause_ms <= cmd.post_pause_ms;
			item_s1.fulfill       <= cmd.fulfill;
		end
	end

	lbs_step #(
		.TIME_BITS  (TIME_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_step (
		.item    (item_s1),
		.st_cur  (st_q),
		.cd_cur  (cd_q),
		.cyc_cur (cyc_q),
		.st_nxt  (st_nxt),
		.cd_nxt  (cd_nxt),
		.cyc_nxt (cyc_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= '0;
			cd_q    <= '0;
			cyc_q   <= '0;
			res_v_q <= 1'b0;
			led_q   <= 1'b0;
			busy_q  <= 1'b0;
		end else if (adv) begin
			st_q    <= st_nxt;
			cd_q    <= cd_nxt;
			cyc_q   <= cyc_nxt;
			res_v_q <= 1'b1;
			led_q   <= st_nxt.led;
			busy_q  <= (st_nxt.phase != lbs_pkg::PH_EMPTY) || st_nxt.pend_valid;
		end else if (res.ready) begin
			res_v_q <= 1'b0;
		end
	end

	assign res.valid     = res_v_q;
	assign res.led_level = led_q;
	assign res.busy_res  = busy_q;

	a_adv_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> res_v_q)
		else $error("step taken without a result");

	a_stall_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		(res_v_q && !res.ready) |=> ($stable(st_q) && $stable(cd_q) && $stable(cyc_q)))
		else $error("state moved while result stalled");

	a_empty_no_time: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == lbs_pkg::PH_EMPTY) |-> (cd_q == '0))
		else $error("countdown running with empty slot");

	a_item_held: assert property (@(posedge clk) disable iff (!arst_n)
		(item_v_s1 && !adv) |=> (item_v_s1 && $stable(item_s1)))
		else $error("input register lost a transaction");

endmodule
`default_nettype wire
